### rtl/fpcl_pkg.sv
// Shared constants, types and helper functions for the parallel configuration loader.
`default_nettype none

package fpcl_pkg;

    localparam int BUS_WIDTH = 32;
    localparam int WORD_W    = 32;
    localparam int TICK_W    = 16;
    localparam int RETRY_W   = 4;
    localparam int CLOCKS_W  = 8;
    localparam int STATUS_W  = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_PULSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_WAIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_BURST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP       = 3'd4;

    // register reset values
    localparam logic [TICK_W-1:0]   RST_PROGRAM_PULSE = 16'd1;
    localparam logic [TICK_W-1:0]   RST_POLL_WAIT     = 16'd1000;
    localparam logic [RETRY_W-1:0]  RST_MAX_RETRIES   = 4'd5;
    localparam logic [CLOCKS_W-1:0] RST_DONE_BURST    = 8'd100;
    localparam logic [CLOCKS_W-1:0] RST_STARTUP       = 8'd8;

    // phase codes, reported on the status output
    localparam logic [STATUS_W-1:0] PH_IDLE        = 4'd0;
    localparam logic [STATUS_W-1:0] PH_PULSE       = 4'd1;
    localparam logic [STATUS_W-1:0] PH_WAIT_INIT   = 4'd2;
    localparam logic [STATUS_W-1:0] PH_LOAD        = 4'd3;
    localparam logic [STATUS_W-1:0] PH_WAIT_DONE   = 4'd4;
    localparam logic [STATUS_W-1:0] PH_STARTUP     = 4'd5;
    localparam logic [STATUS_W-1:0] PH_FINISHED    = 4'd6;
    localparam logic [STATUS_W-1:0] PH_INIT_TO     = 4'd7;
    localparam logic [STATUS_W-1:0] PH_INIT_LOW    = 4'd8;
    localparam logic [STATUS_W-1:0] PH_DONE_TO     = 4'd9;

    localparam logic [RETRY_W-1:0] RETRY_FULL = {RETRY_W{1'b1}};

    typedef struct packed {
        logic [TICK_W-1:0]   program_pulse_ticks;
        logic [TICK_W-1:0]   poll_wait_ticks;
        logic [RETRY_W-1:0]  max_retries;
        logic [CLOCKS_W-1:0] done_burst_clocks;
        logic [CLOCKS_W-1:0] startup_clocks;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] data_word;
        logic              last_word;
        logic              init_level;
        logic              done_level;
    } t_item;

    typedef struct packed {
        logic              program_pin;
        logic              select_pin;
        logic              direction_pin;
        logic              config_clock;
        logic [WORD_W-1:0] data_bus;
        logic [STATUS_W-1:0] status;
        logic              last_of_run;
    } t_result;

    // Mirror the bit order inside every byte; bits at or above the bus width read zero.
    function automatic logic [WORD_W-1:0] lane_swap(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (((b & ~7) | (7 - (b & 7))) < BUS_WIDTH) begin
                r[(b & ~7) | (7 - (b & 7))] = w[b];
            end
        end
        return r;
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

### rtl/fpcl_cfg_regs.sv
// Configuration register file of the parallel configuration loader.
`default_nettype none

module fpcl_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [fpcl_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  wire logic [fpcl_pkg::CFG_DAT_W-1:0]   i_wr_data,
    output fpcl_pkg::t_cfg                        o_cfg
);
    import fpcl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_pulse_ticks <= RST_PROGRAM_PULSE;
            r_cfg.poll_wait_ticks     <= RST_POLL_WAIT;
            r_cfg.max_retries         <= RST_MAX_RETRIES;
            r_cfg.done_burst_clocks   <= RST_DONE_BURST;
            r_cfg.startup_clocks      <= RST_STARTUP;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_PROGRAM_PULSE: r_cfg.program_pulse_ticks <= i_wr_data[TICK_W-1:0];
                CFG_POLL_WAIT:     r_cfg.poll_wait_ticks     <= i_wr_data[TICK_W-1:0];
                CFG_MAX_RETRIES:   r_cfg.max_retries         <= i_wr_data[RETRY_W-1:0];
                CFG_DONE_BURST:    r_cfg.done_burst_clocks   <= i_wr_data[CLOCKS_W-1:0];
                CFG_STARTUP:       r_cfg.startup_clocks      <= i_wr_data[CLOCKS_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/fpcl_ctrl.sv
// Sequencer state and single-pass step logic that turns one command into pin snapshots.
`default_nettype none

module fpcl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire fpcl_pkg::t_item i_item,
    input  wire fpcl_pkg::t_cfg  i_cfg,
    output logic                o_two,
    output fpcl_pkg::t_result   o_first,
    output fpcl_pkg::t_result   o_final
);
    import fpcl_pkg::*;

    logic [STATUS_W-1:0] r_phase,      n_phase;
    logic [TICK_W-1:0]   r_wait_count, n_wait_count;
    logic [RETRY_W-1:0]  r_retry_count, n_retry_count;
    logic [CLOCKS_W-1:0] r_clocks_left, n_clocks_left;
    logic [2:0]          r_control_pins, n_control_pins;
    logic [WORD_W-1:0]   r_bus_value,  n_bus_value;
    logic                pulse;
    logic [TICK_W-1:0]   wait_dec;
    logic [CLOCKS_W-1:0] clocks_dec;
    logic                exhausted;

    assign wait_dec   = r_wait_count - TICK_W'(1);
    assign clocks_dec = r_clocks_left - CLOCKS_W'(1);
    assign exhausted  = (r_retry_count > i_cfg.max_retries) || (r_retry_count == RETRY_FULL);

    always_comb begin
        n_phase        = r_phase;
        n_wait_count   = r_wait_count;
        n_retry_count  = r_retry_count;
        n_clocks_left  = r_clocks_left;
        n_control_pins = r_control_pins;
        n_bus_value    = r_bus_value;
        pulse          = 1'b0;

        if (i_item.cmd == CMD_START) begin
            n_control_pins = '0;
            n_wait_count   = at_least_one(i_cfg.program_pulse_ticks);
            n_retry_count  = '0;
            n_clocks_left  = '0;
            n_phase        = PH_PULSE;
        end else if (i_item.cmd == CMD_DATA) begin
            if (r_phase == PH_LOAD) begin
                n_bus_value = lane_swap(i_item.data_word);
                pulse       = 1'b1;
                if (i_item.last_word) begin
                    if (!i_item.init_level) begin
                        n_phase = PH_INIT_LOW;
                    end else begin
                        n_phase       = PH_WAIT_DONE;
                        n_wait_count  = '0;
                        n_retry_count = '0;
                        n_clocks_left = '0;
                    end
                end
            end
        end else begin
            case (r_phase)
                PH_PULSE: begin
                    n_wait_count = wait_dec;
                    if (wait_dec == '0) begin
                        // release program
                        n_control_pins = r_control_pins | 3'b100;
                        n_phase        = PH_WAIT_INIT;
                    end
                end
                PH_WAIT_INIT: begin
                    if (r_wait_count == '0) begin
                        if (i_item.init_level) begin
                            n_phase = PH_LOAD;
                        end else begin
                            n_wait_count = at_least_one(i_cfg.poll_wait_ticks);
                        end
                    end else begin
                        n_wait_count = wait_dec;
                        if (wait_dec == '0) begin
                            if (exhausted) begin
                                n_phase = PH_INIT_TO;
                            end else begin
                                n_retry_count = r_retry_count + RETRY_W'(1);
                            end
                        end
                    end
                end
                PH_WAIT_DONE: begin
                    if (r_clocks_left != '0) begin
                        n_clocks_left = clocks_dec;
                        pulse         = 1'b1;
                    end else if (r_wait_count != '0) begin
                        n_wait_count = wait_dec;
                        if (wait_dec == '0) begin
                            if (exhausted) begin
                                n_phase = PH_DONE_TO;
                            end else begin
                                n_retry_count = r_retry_count + RETRY_W'(1);
                            end
                        end
                    end else if (i_item.done_level) begin
                        n_clocks_left = i_cfg.startup_clocks;
                        n_phase = (i_cfg.startup_clocks == '0) ? PH_FINISHED : PH_STARTUP;
                    end else begin
                        // failed poll: send a clock burst, then wait
                        n_clocks_left = i_cfg.done_burst_clocks;
                        n_wait_count  = at_least_one(i_cfg.poll_wait_ticks);
                    end
                end
                PH_STARTUP: begin
                    if (r_clocks_left != '0) begin
                        n_clocks_left = clocks_dec;
                        pulse         = 1'b1;
                        if (clocks_dec == '0) begin
                            n_phase = PH_FINISHED;
                        end
                    end else begin
                        n_phase = PH_FINISHED;
                    end
                end
                default: begin
                    // idle, load, finished and error phases hold on a tick
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_wait_count   <= '0;
            r_retry_count  <= '0;
            r_clocks_left  <= '0;
            r_control_pins <= '0;
            r_bus_value    <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_wait_count   <= n_wait_count;
            r_retry_count  <= n_retry_count;
            r_clocks_left  <= n_clocks_left;
            r_control_pins <= n_control_pins;
            r_bus_value    <= n_bus_value;
        end
    end

    // clock-high snapshot reports the phase before this step
    always_comb begin
        o_first.program_pin   = n_control_pins[2];
        o_first.select_pin    = n_control_pins[1];
        o_first.direction_pin = n_control_pins[0];
        o_first.config_clock  = 1'b1;
        o_first.data_bus      = n_bus_value;
        o_first.status        = r_phase;
        o_first.last_of_run   = 1'b0;

        o_final.program_pin   = n_control_pins[2];
        o_final.select_pin    = n_control_pins[1];
        o_final.direction_pin = n_control_pins[0];
        o_final.config_clock  = 1'b0;
        o_final.data_bus      = n_bus_value;
        o_final.status        = n_phase;
        o_final.last_of_run   = 1'b1;
    end

    assign o_two = pulse;

endmodule

`default_nettype wire

### rtl/fpcl_out_queue.sv
// Two-slot result register: output register plus one pending slot for the clock-low beat.
`default_nettype none

module fpcl_out_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic             i_two,
    input  wire fpcl_pkg::t_result i_first,
    input  wire fpcl_pkg::t_result i_final,
    output logic                  o_can_push,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output fpcl_pkg::t_result     o_result
);
    import fpcl_pkg::*;

    logic    r_out_valid;
    logic    r_pend_valid;
    t_result r_out;
    t_result r_pend;
    logic    out_take;

    assign out_take   = r_out_valid && i_ready;
    assign o_can_push = !r_pend_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_push) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= i_two;
        end else if (out_take) begin
            if (r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_out  <= i_two ? i_first : i_final;
            r_pend <= i_final;
        end else if (out_take && r_pend_valid) begin
            // advance the pending clock-low beat
            r_out <= r_pend;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### rtl/fpcl_config_loader_top.sv
// Empty compilation unit kept beside the loader sources; it declares no module.
`default_nettype none

`default_nettype wire

### rtl/fpga_parallel_config_loader_top.sv
// Parallel FPGA configuration loader: input register, sequencer and result buffer.
// Each accepted command is registered, then stepped through the sequencer, which yields
// one pin snapshot, or two (clock high, then clock low) when the step sends a configuration
// clock pulse (a data word in the load phase, a done burst clock or a startup clock). The
// last beat of every command carries last_of_run. Commands that give one beat flow at one
// per cycle while results are taken; commands that pulse the clock are bounded by the single
// output port draining the two snapshots. The first result passes through the input register
// and then the output register. Configuration writes are taken in any cycle and should be
// issued only while no command is in flight.
`default_nettype none

module fpga_parallel_config_loader_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fpcl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fpcl_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [fpcl_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [fpcl_pkg::WORD_W-1:0]      i_data_word,
    input  wire logic                             i_last_word,
    input  wire logic                             i_init_level,
    input  wire logic                             i_done_level,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_program_pin,
    output logic                                  o_select_pin,
    output logic                                  o_direction_pin,
    output logic                                  o_config_clock,
    output logic [fpcl_pkg::WORD_W-1:0]           o_data_bus,
    output logic [fpcl_pkg::STATUS_W-1:0]         o_status,
    output logic                                  o_last_of_run
);
    import fpcl_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    logic    step;
    logic    can_push;
    logic    two;
    t_result first_res;
    t_result final_res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    fpcl_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign step    = r_in_valid && can_push;
    assign o_ready = !r_in_valid || can_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.cmd        <= i_cmd;
            r_item.data_word  <= i_data_word;
            r_item.last_word  <= i_last_word;
            r_item.init_level <= i_init_level;
            r_item.done_level <= i_done_level;
        end
    end

    fpcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_two   (two),
        .o_first (first_res),
        .o_final (final_res)
    );

    fpcl_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_two      (two),
        .i_first    (first_res),
        .i_final    (final_res),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_res)
    );

    assign o_program_pin   = out_res.program_pin;
    assign o_select_pin    = out_res.select_pin;
    assign o_direction_pin = out_res.direction_pin;
    assign o_config_clock  = out_res.config_clock;
    assign o_data_bus      = out_res.data_bus;
    assign o_status        = out_res.status;
    assign o_last_of_run   = out_res.last_of_run;

endmodule

`default_nettype wire

### bench/tb_fpga_parallel_config_loader_top.sv
// Self-checking bench for the parallel configuration loader against a built-in predictor.
module tb_fpga_parallel_config_loader_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpcl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_ALT_TICK = 2'd3;   // unused code, behaves as a tick
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 200;
    localparam int QUIET_FROM    = 350;
    localparam int QUIET_TO      = 500;
    localparam int IDLE_PCT      = 7;
    localparam int TOTAL_ITEMS   = 600;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_cmd = CMD_TICK;
    logic [WORD_W-1:0]    i_data_word = '0;
    logic                 i_last_word = 1'b0;
    logic                 i_init_level = 1'b0;
    logic                 i_done_level = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_program_pin;
    logic                 o_select_pin;
    logic                 o_direction_pin;
    logic                 o_config_clock;
    logic [WORD_W-1:0]    o_data_bus;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last_of_run;

    fpga_parallel_config_loader_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_data_word    (i_data_word),
        .i_last_word    (i_last_word),
        .i_init_level   (i_init_level),
        .i_done_level   (i_done_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_program_pin  (o_program_pin),
        .o_select_pin   (o_select_pin),
        .o_direction_pin(o_direction_pin),
        .o_config_clock (o_config_clock),
        .o_data_bus     (o_data_bus),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: register copy and sequencer state
    t_cfg                ld_cfg;
    logic [STATUS_W-1:0] ld_phase;
    logic [TICK_W-1:0]   ld_wait;
    logic [RETRY_W-1:0]  ld_retry;
    logic [CLOCKS_W-1:0] ld_clocks;
    logic                ld_clk;
    logic [2:0]          ld_pins;
    logic [WORD_W-1:0]   ld_bus;

    t_item   pending_cmds[$];
    t_result expected_pins[$];
    t_item   offered;
    t_result want;

    int n_queued = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic quiet_span;

    assign quiet_span = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

    function automatic logic [WORD_W-1:0] swap_lanes(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < WORD_W / 8; k++) begin
            for (int j = 0; j < 8; j++) begin
                if (8 * k + 7 - j < BUS_WIDTH) begin
                    r[8 * k + 7 - j] = w[8 * k + j];
                end
            end
        end
        return r;
    endfunction

    function automatic logic [TICK_W-1:0] pulse_len();
        return (ld_cfg.program_pulse_ticks == '0) ? TICK_W'(1) : ld_cfg.program_pulse_ticks;
    endfunction

    function automatic logic [TICK_W-1:0] poll_len();
        return (ld_cfg.poll_wait_ticks == '0) ? TICK_W'(1) : ld_cfg.poll_wait_ticks;
    endfunction

    function automatic t_result pin_snapshot(input logic last);
        t_result r;
        r.program_pin   = ld_pins[2];
        r.select_pin    = ld_pins[1];
        r.direction_pin = ld_pins[0];
        r.config_clock  = ld_clk;
        r.data_bus      = ld_bus;
        r.status        = ld_phase;
        r.last_of_run   = last;
        return r;
    endfunction

    // A poll that ran out of wait: timeout once the count passes the limit or is full.
    function automatic bit retry_spent();
        if (ld_retry > ld_cfg.max_retries || ld_retry == RETRY_FULL) begin
            return 1'b1;
        end
        ld_retry = ld_retry + RETRY_W'(1);
        return 1'b0;
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    task automatic reset_model();
        ld_cfg.program_pulse_ticks = RST_PROGRAM_PULSE;
        ld_cfg.poll_wait_ticks     = RST_POLL_WAIT;
        ld_cfg.max_retries         = RST_MAX_RETRIES;
        ld_cfg.done_burst_clocks   = RST_DONE_BURST;
        ld_cfg.startup_clocks      = RST_STARTUP;
        ld_phase  = PH_IDLE;
        ld_wait   = '0;
        ld_retry  = '0;
        ld_clocks = '0;
        ld_clk    = 1'b0;
        ld_pins   = '0;
        ld_bus    = '0;
    endtask

    task automatic send_pulse();
        ld_clk = 1'b1;
        expected_pins.push_back(pin_snapshot(1'b0));
        ld_clk = 1'b0;
    endtask

    task automatic predict_step(input t_item it);
        if (it.cmd == CMD_START) begin
            ld_pins   = '0;
            ld_clk    = 1'b0;
            ld_wait   = pulse_len();
            ld_retry  = '0;
            ld_clocks = '0;
            ld_phase  = PH_PULSE;
        end else if (it.cmd == CMD_DATA) begin
            if (ld_phase == PH_LOAD) begin
                ld_bus = swap_lanes(it.data_word);
                send_pulse();
                if (it.last_word) begin
                    if (!it.init_level) begin
                        ld_phase = PH_INIT_LOW;
                    end else begin
                        ld_phase  = PH_WAIT_DONE;
                        ld_wait   = '0;
                        ld_retry  = '0;
                        ld_clocks = '0;
                    end
                end
            end
        end else if (ld_phase == PH_PULSE) begin
            ld_wait = ld_wait - TICK_W'(1);
            if (ld_wait == '0) begin
                ld_pins[2] = 1'b1;
                ld_phase   = PH_WAIT_INIT;
            end
        end else if (ld_phase == PH_WAIT_INIT) begin
            if (ld_wait == '0) begin
                if (it.init_level) begin
                    ld_phase = PH_LOAD;
                end else begin
                    ld_wait = poll_len();
                end
            end else begin
                ld_wait = ld_wait - TICK_W'(1);
                if (ld_wait == '0 && retry_spent()) begin
                    ld_phase = PH_INIT_TO;
                end
            end
        end else if (ld_phase == PH_WAIT_DONE) begin
            if (ld_clocks != '0) begin
                ld_clocks = ld_clocks - CLOCKS_W'(1);
                send_pulse();
            end else if (ld_wait != '0) begin
                ld_wait = ld_wait - TICK_W'(1);
                if (ld_wait == '0 && retry_spent()) begin
                    ld_phase = PH_DONE_TO;
                end
            end else if (it.done_level) begin
                ld_clocks = ld_cfg.startup_clocks;
                ld_phase  = (ld_clocks == '0) ? PH_FINISHED : PH_STARTUP;
            end else begin
                ld_clocks = ld_cfg.done_burst_clocks;
                ld_wait   = poll_len();
            end
        end else if (ld_phase == PH_STARTUP) begin
            if (ld_clocks != '0) begin
                ld_clocks = ld_clocks - CLOCKS_W'(1);
                send_pulse();
            end
            if (ld_clocks == '0) begin
                ld_phase = PH_FINISHED;
            end
        end
        expected_pins.push_back(pin_snapshot(1'b1));
    endtask

    task automatic add_item(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] w,
                            input logic lw, input logic il, input logic dl);
        t_item it;
        it.cmd        = c;
        it.data_word  = w;
        it.last_word  = lw;
        it.init_level = il;
        it.done_level = dl;
        pending_cmds.push_back(it);
        n_queued++;
    endtask

    task automatic add_tick(input logic il, input logic dl);
        add_item(($urandom_range(9) == 0) ? CMD_ALT_TICK : CMD_TICK, $urandom, rbit(), il, dl);
    endtask

    task automatic maybe_noise(input int pct);
        if ($urandom_range(99) < pct) begin
            add_item(CMD_W'($urandom_range(3)), $urandom, rbit(), rbit(), rbit());
        end
    endtask

    // One configuration run: start, pulse, init polls, words, done polls, startup clocks.
    task automatic queue_run(input int init_fail, input int done_fail, input int noise);
        int  tries;
        int  limit;
        int  n_words;
        bit  ok;
        logic lvl;
        limit = (int'(ld_cfg.max_retries) + 2 > 16) ? 16 : int'(ld_cfg.max_retries) + 2;
        maybe_noise(noise);
        add_item(CMD_START, $urandom, rbit(), rbit(), rbit());
        repeat (int'(pulse_len())) add_tick(rbit(), rbit());
        tries = 0;
        ok = 1'b0;
        while (!ok && tries < limit) begin
            if ($urandom_range(99) < init_fail) begin
                add_tick(1'b0, rbit());
                repeat (int'(poll_len())) add_tick(rbit(), rbit());
                tries++;
            end else begin
                add_tick(1'b1, rbit());
                ok = 1'b1;
            end
        end
        if (!ok) begin
            add_tick(rbit(), rbit());
            return;
        end
        maybe_noise(noise);
        n_words = $urandom_range(1, 6);
        lvl = 1'b1;
        for (int k = 0; k < n_words; k++) begin
            if (k == n_words - 1) begin
                lvl = ($urandom_range(99) < init_fail / 2) ? 1'b0 : 1'b1;
                add_item(CMD_DATA, $urandom, 1'b1, lvl, rbit());
            end else begin
                add_item(CMD_DATA, $urandom, 1'b0, rbit(), rbit());
            end
        end
        if (!lvl) begin
            add_tick(rbit(), rbit());
            return;
        end
        maybe_noise(noise);
        tries = 0;
        ok = 1'b0;
        while (!ok && tries < limit) begin
            if ($urandom_range(99) < done_fail) begin
                add_tick(rbit(), 1'b0);
                repeat (int'(ld_cfg.done_burst_clocks)) add_tick(rbit(), rbit());
                repeat (int'(poll_len())) add_tick(rbit(), rbit());
                tries++;
            end else begin
                add_tick(rbit(), 1'b1);
                ok = 1'b1;
            end
        end
        if (ok) begin
            repeat (int'(ld_cfg.startup_clocks)) add_tick(rbit(), rbit());
        end
        add_tick(rbit(), rbit());
        maybe_noise(noise);
    endtask

    // Keep valid up across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PROGRAM_PULSE: ld_cfg.program_pulse_ticks = val;
            CFG_POLL_WAIT:     ld_cfg.poll_wait_ticks     = val;
            CFG_MAX_RETRIES:   ld_cfg.max_retries         = val[RETRY_W-1:0];
            CFG_DONE_BURST:    ld_cfg.done_burst_clocks   = val[CLOCKS_W-1:0];
            CFG_STARTUP:       ld_cfg.startup_clocks      = val[CLOCKS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input int prog, input int poll, input int retries,
                             input int burst, input int startup);
        write_reg(CFG_PROGRAM_PULSE, CFG_DAT_W'(prog));
        write_reg(CFG_POLL_WAIT, CFG_DAT_W'(poll));
        write_reg(CFG_MAX_RETRIES, CFG_DAT_W'(retries));
        write_reg(CFG_DONE_BURST, CFG_DAT_W'(burst));
        write_reg(CFG_STARTUP, CFG_DAT_W'(startup));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || i_valid || expected_pins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_step(offered);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_cmds.size() != 0 && (quiet_span || $urandom_range(99) >= IDLE_PCT)) begin
                    offered = pending_cmds.pop_front();
                    i_cmd        <= offered.cmd;
                    i_data_word  <= offered.data_word;
                    i_last_word  <= offered.last_word;
                    i_init_level <= offered.init_level;
                    i_done_level <= offered.done_level;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure, with one long hold-off while commands keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT && pending_cmds.size() > 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (quiet_span) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected beat, status %0d", $time, o_status);
                n_errors++;
            end else begin
                want = expected_pins.pop_front();
                check_field("program_pin", 32'(want.program_pin), 32'(o_program_pin));
                check_field("select_pin", 32'(want.select_pin), 32'(o_select_pin));
                check_field("direction_pin", 32'(want.direction_pin), 32'(o_direction_pin));
                check_field("config_clock", 32'(want.config_clock), 32'(o_config_clock));
                check_field("data_bus", want.data_bus, o_data_bus);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("last_of_run", 32'(want.last_of_run), 32'(o_last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on reset register values
        add_tick(1'b0, 1'b0);
        add_item(CMD_ALT_TICK, 32'h0, 1'b0, 1'b1, 1'b1);
        add_item(CMD_DATA, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
        add_item(CMD_DATA, 32'h1234_5678, 1'b1, 1'b1, 1'b1);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);
        add_item(CMD_DATA, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
        add_item(CMD_DATA, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        add_item(CMD_DATA, 32'h8040_2010, 1'b0, 1'b1, 1'b1);
        add_item(CMD_START, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_tick(1'b1, 1'b1);
        add_tick(1'b1, 1'b1);
        add_item(CMD_DATA, 32'hA5C3_0F01, 1'b1, 1'b0, 1'b1);
        add_tick(1'b1, 1'b1);
        add_item(CMD_DATA, 32'h0102_0408, 1'b1, 1'b1, 1'b1);
        add_item(CMD_START, 32'h0, 1'b0, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b0);
        add_item(CMD_DATA, 32'h7FFF_FFFE, 1'b1, 1'b1, 1'b0);
        add_tick(1'b0, 1'b1);
        repeat (9) add_tick(rbit(), rbit());

        // all registers at zero: zero lengths act as one tick, no startup clocks
        wait_idle();
        load_regs(0, 0, 0, 0, 0);
        repeat (6) queue_run(50, 50, 10);

        // top of every range; the pulse alone is too long to finish, so restart it
        wait_idle();
        load_regs(16'hFFFF, 16'hFFFF, 15, 255, 255);
        add_item(CMD_START, $urandom, rbit(), rbit(), rbit());
        repeat (6) add_tick(rbit(), rbit());
        add_item(CMD_DATA, $urandom, 1'b1, 1'b1, 1'b1);
        add_item(CMD_START, $urandom, rbit(), rbit(), rbit());
        repeat (4) add_tick(rbit(), rbit());

        // longest bursts with every poll passing at once
        wait_idle();
        load_regs(1, 16'hFFFF, 15, 255, 255);
        queue_run(0, 0, 0);

        // retry counter runs full before the timeout
        wait_idle();
        load_regs(1, 1, 15, 1, 1);
        queue_run(100, 0, 0);
        queue_run(0, 100, 0);
        repeat (3) queue_run(60, 60, 5);

        // random register sets until the item budget is used
        do begin
            wait_idle();
            load_regs($urandom_range(0, 3), $urandom_range(0, 4),
                      ($urandom_range(9) == 0) ? 15 : $urandom_range(0, 4),
                      $urandom_range(0, 5), $urandom_range(0, 6));
            repeat (4) queue_run(35, 35, 12);
        end while (n_queued < TOTAL_ITEMS);

        wait_idle();
        if (n_errors == 0 && expected_pins.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
